// ===== rtl/core/integer_matrix_multiply_macros.svh =====
// ---------------------------------------------------------------------------
// integer_matrix_multiply_macros.svh
// Assertion macros for the integer matrix multiply block.
// ---------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define IMM_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imm assertion failed");
// next-cycle implication
`define IMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imm assertion failed");
`else
`define IMM_ASSERT(lbl, ante, cons)
`define IMM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/imm_pkg.sv =====
// ---------------------------------------------------------------------------
// imm_pkg
// Shared types, codes and defaults for the integer matrix multiply block.
// ---------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM_DFLT    = 8;
  localparam int DATA_WIDTH_DFLT = 32;
  localparam int CFG_W           = 4;
  localparam int POS_W           = 3;   // row / col field width
  localparam int FIFO_DEPTH      = 8;
  localparam int FIFO_AW         = 3;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ROWS_A = 2'd0,
    REG_INNER  = 2'd1,
    REG_COLS_B = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // tag that travels with a partial sum down the cell row
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } tag_t;

  // 0 acts as 1, above the maximum acts as the maximum
  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                               input logic [CFG_W-1:0] maxd);
    logic [CFG_W-1:0] res;
    res = v;
    if (v == '0) res = CFG_W'(1);
    else if (v > maxd) res = maxd;
    return res;
  endfunction

endpackage

// ===== rtl/core/integer_matrix_multiply.sv =====
// ---------------------------------------------------------------------------
// integer_matrix_multiply
// Integer matrix product P = A * B over stores loaded word by word.
// ---------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// in_      in   in_tvalid/tready   tuser: command; tdata: row, col, value
// out_     out  out_tvalid/tready  tdata: product_value, row, col; tlast
// cfg_     in   cfg_valid/ready    cfg_index, cfg_data (4-bit dimension)
//
// A load word does one RAM write. A run word issues one A/B read pair per
// cycle from the two store RAMs into one multiplier, except while a new dot
// product waits for a free result FIFO slot; each term passes through the
// RAM read, the multiply and the cell row. The input is held off while
// a run issues. Reset (rst_n, synchronous) clears control only; the stores
// hold garbage until written. Output stalls are absorbed by an 8-word
// result FIFO; issue pauses while it would overflow.
// ---------------------------------------------------------------------------
`include "integer_matrix_multiply_macros.svh"

module integer_matrix_multiply #(
  parameter int MAX_DIM    = imm_pkg::MAX_DIM_DFLT,
  parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [2:0] row_index, [5:3] col_index,
                                  // [37:6] value, [39:38] zero
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] product_value, [34:32] out_row,
                                  // [37:35] out_col, [39:38] zero
  output logic        out_tlast,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import imm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PW    = $clog2(FIFO_DEPTH + 1);

  // ---- configuration registers ----
  logic [CFG_W-1:0] rows_a_r, inner_r, cols_b_r;
  logic [CFG_W-1:0] nr, nk, nc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= CFG_W'(8);
      inner_r  <= CFG_W'(8);
      cols_b_r <= CFG_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_ROWS_A: rows_a_r <= cfg_data;
        REG_INNER:  inner_r  <= cfg_data;
        REG_COLS_B: cols_b_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign nr = eff_dim(rows_a_r, CFG_W'(MAX_DIM));
  assign nk = eff_dim(inner_r,  CFG_W'(MAX_DIM));
  assign nc = eff_dim(cols_b_r, CFG_W'(MAX_DIM));

  // ---- input word unpack ----
  logic               in_acc;
  cmd_t               in_cmd;
  logic [POS_W-1:0]   in_row, in_col;
  logic signed [31:0] in_value;

  assign in_acc   = in_tvalid && in_tready;
  assign in_cmd   = cmd_t'(in_tuser);
  assign in_row   = in_tdata[2:0];
  assign in_col   = in_tdata[5:3];
  assign in_value = in_tdata[37:6];

  // ---- store writes ----
  logic                  wr_in_range;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  wr_a, wr_b;

  assign wr_in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign wr_addr     = AW'(int'(in_row) * MAX_DIM + int'(in_col));
  assign wr_data     = DATA_WIDTH'(in_value);   // sign-extend or truncate
  assign wr_a        = in_acc && wr_in_range && (in_cmd == CMD_LOAD_A);
  assign wr_b        = in_acc && wr_in_range && (in_cmd == CMD_LOAD_B);

  // ---- sequencer ----
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;
  logic [PW-1:0]    pend_r, pend_nxt;
  logic             issue, k_end, c_end, r_end, pop, push;
  logic [AW-1:0]    rd_addr_a, rd_addr_b;

  assign k_end = (CFG_W'(k_r) + CFG_W'(1)) == nk;
  assign c_end = (CFG_W'(c_r) + CFG_W'(1)) == nc;
  assign r_end = (CFG_W'(r_r) + CFG_W'(1)) == nr;

  // a new dot product only starts if its result has a FIFO slot reserved
  assign issue = (state_r == ST_RUN) &&
                 ((k_r != '0) || (pend_r < PW'(FIFO_DEPTH)));

  assign rd_addr_a = AW'(int'(r_r) * MAX_DIM + int'(k_r));
  assign rd_addr_b = AW'(int'(k_r) * MAX_DIM + int'(c_r));

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc && (in_cmd == CMD_RUN)) begin
          state_nxt = ST_RUN;
          r_nxt     = '0;
          c_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (!k_end) begin
            k_nxt = k_r + IDX_W'(1);
          end else begin
            k_nxt = '0;
            if (!c_end) begin
              c_nxt = c_r + IDX_W'(1);
            end else begin
              c_nxt = '0;
              if (!r_end) begin
                r_nxt = r_r + IDX_W'(1);
              end else begin
                state_nxt = ST_IDLE;
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
    end
  end

  // results reserved: issued dot products not yet taken at the output
  always_comb begin
    pend_nxt = pend_r;
    if (issue && (k_r == '0)) pend_nxt = pend_nxt + PW'(1);
    if (pop)                  pend_nxt = pend_nxt - PW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else        pend_r <= pend_nxt;
  end

  // ---- stores ----
  logic [DATA_WIDTH-1:0] a_rd, b_rd;

  imm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH), .AW(AW)) u_store_a (
    .clk    (clk),
    .wr_en  (wr_a),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr_a),
    .rd_data(a_rd)
  );

  imm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH), .AW(AW)) u_store_b (
    .clk    (clk),
    .wr_en  (wr_b),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr_b),
    .rd_data(b_rd)
  );

  // ---- read and multiply stages ----
  tag_t                  s1_tag_r, s1_tag_nxt, s2_tag_r;
  logic [IDX_W-1:0]      s1_k_r, s2_k_r;
  logic [DATA_WIDTH-1:0] mult, s2_prod_r;

  always_comb begin
    s1_tag_nxt.valid = issue;
    s1_tag_nxt.last  = r_end && c_end;
    s1_tag_nxt.row   = POS_W'(r_r);
    s1_tag_nxt.col   = POS_W'(c_r);
  end

  // low DATA_WIDTH bits are the same for signed and unsigned operands
  assign mult = a_rd * b_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r.valid <= 1'b0;
      s2_tag_r.valid <= 1'b0;
    end else begin
      s1_tag_r.valid <= s1_tag_nxt.valid;
      s2_tag_r.valid <= s1_tag_r.valid;
    end
    s1_tag_r.last <= s1_tag_nxt.last;
    s1_tag_r.row  <= s1_tag_nxt.row;
    s1_tag_r.col  <= s1_tag_nxt.col;
    s1_k_r        <= k_r;
    s2_tag_r.last <= s1_tag_r.last;
    s2_tag_r.row  <= s1_tag_r.row;
    s2_tag_r.col  <= s1_tag_r.col;
    s2_k_r        <= s1_k_r;
    s2_prod_r     <= mult;
  end

  // ---- cell row: sum walks one cell per cycle, cell k adds term k ----
  tag_t                  cell_tag [MAX_DIM];
  logic [DATA_WIDTH-1:0] cell_sum [MAX_DIM];

  for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
    tag_t                  prev_tag;
    logic [DATA_WIDTH-1:0] prev_sum;
    if (i == 0) begin : g_head
      assign prev_tag = '0;
      assign prev_sum = '0;
    end else begin : g_link
      assign prev_tag = cell_tag[i-1];
      assign prev_sum = cell_sum[i-1];
    end
    imm_cell #(.DATA_WIDTH(DATA_WIDTH), .IDX_W(IDX_W), .INDEX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .prod_tag (s2_tag_r),
      .prod_k   (s2_k_r),
      .prod_data(s2_prod_r),
      .prev_tag (prev_tag),
      .prev_sum (prev_sum),
      .cell_tag (cell_tag[i]),
      .cell_sum (cell_sum[i])
    );
  end

  // tap after cell nk-1
  logic [IDX_W-1:0] tap_idx;
  tag_t             tap_tag;
  logic [31:0]      tap_val;

  assign tap_idx = IDX_W'(nk - CFG_W'(1));
  assign tap_tag = cell_tag[tap_idx];
  assign tap_val = 32'(cell_sum[tap_idx]);
  assign push    = tap_tag.valid;

  // ---- result FIFO ----
  localparam int RW = 32 + 2 * POS_W + 1;

  logic [RW-1:0]      fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [PW-1:0]      cnt_r, cnt_nxt;
  logic [RW-1:0]      head;

  assign pop = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= {tap_tag.last, tap_tag.col, tap_tag.row, tap_val};
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push) cnt_nxt = cnt_nxt + PW'(1);
    if (pop)  cnt_nxt = cnt_nxt - PW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + FIFO_AW'(1);
      if (pop)  rp_r <= rp_r + FIFO_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  assign head       = fifo_r[rp_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {2'b00, head[RW-2:0]};
  assign out_tlast  = head[RW-1];

  // ---- assertions ----
  `IMM_ASSERT(a_pend_cap, 1'b1, pend_r <= PW'(FIFO_DEPTH))
  `IMM_ASSERT(a_no_overflow, push, cnt_r < PW'(FIFO_DEPTH) || pop)
  `IMM_ASSERT(a_fifo_reserved, 1'b1, cnt_r <= pend_r)
  `IMM_ASSERT_NEXT(a_run_start, in_acc && (in_cmd == CMD_RUN), state_r == ST_RUN)

endmodule

// ===== rtl/core/imm_ram.sv =====
// ---------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/imm_cell.sv =====
// ---------------------------------------------------------------------------
// imm_cell
// One accumulate cell: adds the broadcast product for its inner index to
// the partial sum handed over by its left neighbor (cell 0 starts a new sum).
// ---------------------------------------------------------------------------
module imm_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 3,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  imm_pkg::tag_t         prod_tag,
  input  logic [IDX_W-1:0]      prod_k,
  input  logic [DATA_WIDTH-1:0] prod_data,
  input  imm_pkg::tag_t         prev_tag,
  input  logic [DATA_WIDTH-1:0] prev_sum,
  output imm_pkg::tag_t         cell_tag,
  output logic [DATA_WIDTH-1:0] cell_sum
);
  import imm_pkg::*;

  tag_t                  tag_r, tag_nxt;
  logic [DATA_WIDTH-1:0] sum_r, sum_nxt;
  logic                  hit;

  assign hit = prod_tag.valid && (prod_k == IDX_W'(INDEX));

  always_comb begin
    if (INDEX == 0) begin
      // head of the row: a new dot product starts here
      tag_nxt       = prod_tag;
      tag_nxt.valid = hit;
      sum_nxt       = prod_data;
    end else begin
      tag_nxt = prev_tag;
      sum_nxt = prev_sum + (hit ? prod_data : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else begin
      tag_r.valid <= tag_nxt.valid;
    end
    tag_r.last <= tag_nxt.last;
    tag_r.row  <= tag_nxt.row;
    tag_r.col  <= tag_nxt.col;
    sum_r      <= sum_nxt;
  end

  assign cell_tag = tag_r;
  assign cell_sum = sum_r;

endmodule
